// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the UART line command decoder.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ULCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ULCD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ULCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ULCD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/ulcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, keyword table and helpers for the UART line command decoder.
// No dependencies.
package ulcd_pkg;

	localparam int KW_COUNT = 6;
	localparam int KW_MAX   = 22;
	localparam int KW_W     = KW_MAX * 8;
	localparam int KW_IDX_W = 3;
	localparam int KW_K_W   = 5;
	localparam int MODE_W   = 3;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic       KIND_BYTE = 1'b0;
	localparam logic       KIND_POLL = 1'b1;

	// common leading text of every keyword
	localparam logic [31:0] KW_HEAD = "led_";

	// keyword text, right-justified; first character in the highest used byte
	localparam logic [KW_W-1:0] KW_TEXT [KW_COUNT] = '{
		KW_W'({KW_HEAD, "shift_left_on"}),
		KW_W'({KW_HEAD, "shift_right_on"}),
		KW_W'({KW_HEAD, "shift_left_keepon"}),
		KW_W'({KW_HEAD, "shift_right_keepon"}),
		KW_W'({KW_HEAD, "flower_on"}),
		KW_W'({KW_HEAD, "flower_off"})
	};
	localparam logic [KW_K_W-1:0] KW_LEN [KW_COUNT] = '{
		5'd17, 5'd18, 5'd21, 5'd22, 5'd13, 5'd14
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic              done;
		logic              hit;
		logic [MODE_W-1:0] mode;
	} match_stat_t;

	typedef struct packed {
		logic              dropped;
		logic              hit;
		logic              taken;
		logic [MODE_W-1:0] mode;
	} result_t;

	// character k of keyword w, zero past its end
	function automatic logic [7:0] kw_char(logic [KW_IDX_W-1:0] w, logic [KW_K_W-1:0] k);
		logic [KW_K_W-1:0] pos;
		logic [7:0]        res;
		pos = KW_LEN[w] - 5'd1 - k;
		if (k >= KW_LEN[w])
			res = 8'h00;
		else
			res = KW_TEXT[w][{pos, 3'b000} +: 8];
		return res;
	endfunction

endpackage

// ===== hw/rtl/ulcd_line_ram.sv =====
`timescale 1ns / 1ps
// Line store: one write port, one read port with registered read data.
// Depends on nothing.
module ulcd_line_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/ulcd_matcher.sv =====
`timescale 1ns / 1ps
// Keyword matcher: walks one stored line a character per cycle and tracks
// which keywords are still alive. Depends on ulcd_pkg.
module ulcd_matcher #(
	parameter int ADDR_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ADDR_W-1:0]     base,
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr,
	input  logic [7:0]            rd_data,
	output ulcd_pkg::match_stat_t stat
);
	import ulcd_pkg::*;

	logic                    active_q;
	logic [ADDR_W-1:0]       base_q;
	logic [KW_K_W-1:0]       k_q;
	logic [KW_K_W-1:0]       k_s1;
	logic                    cmp_valid_s1;
	logic [KW_COUNT-1:0]     alive_q;
	logic [KW_COUNT-1:0]     found_q;
	logic [KW_COUNT-1:0]     alive_nxt;
	logic [KW_COUNT-1:0]     found_nxt;
	logic                    done;
	logic                    issue;
	logic [MODE_W-1:0]       mode_sel;

	always_comb begin
		logic m;
		logic last;
		for (int w = 0; w < KW_COUNT; w++) begin
			m = alive_q[w] && (rd_data == kw_char(KW_IDX_W'(w), k_s1));
			last = (k_s1 == KW_LEN[w] - 5'd1);
			found_nxt[w] = found_q[w] | (m & last);
			alive_nxt[w] = m & ~last;
		end
		// lowest index wins
		mode_sel = '0;
		for (int w = KW_COUNT - 1; w >= 0; w--) begin
			if (found_nxt[w])
				mode_sel = MODE_W'(w);
		end
	end

	assign done    = cmp_valid_s1 && (alive_nxt == '0);
	assign issue   = active_q && !done && (k_q < KW_K_W'(KW_MAX));
	assign rd_en   = issue;
	assign rd_addr = base_q + ADDR_W'(k_q);

	assign stat.done = done;
	assign stat.hit  = |found_nxt;
	assign stat.mode = mode_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			k_q          <= '0;
			alive_q      <= '0;
			found_q      <= '0;
		end else if (start) begin
			active_q     <= 1'b1;
			cmp_valid_s1 <= 1'b0;
			k_q          <= '0;
			alive_q      <= '1;
			found_q      <= '0;
		end else if (active_q) begin
			cmp_valid_s1 <= issue;
			if (issue)
				k_q <= k_q + 5'd1;
			if (cmp_valid_s1) begin
				alive_q <= alive_nxt;
				found_q <= found_nxt;
			end
			if (done)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			base_q <= base;
		k_s1 <= k_q;
	end

endmodule

// ===== hw/rtl/uart_line_command_decoder_top.sv =====
`timescale 1ns / 1ps
// A received byte or a poll of an empty ring goes through ST_DONE to the output register;
// a poll of a stored line first passes through ST_MATCH, one line character read
// per cycle from the single line RAM read port (keywords of at most 22 characters).
// One request is handled at a time: the next is taken only once the last result is loaded,
// which waits while the previous result is still held in the output register.
// Reset clears pointers, column, mode and handshake state; line RAM is not cleared.
`include "assert_macros.svh"
module uart_line_command_decoder_top #(
	parameter int QUEUE_DEPTH = 8,
	parameter int LINE_LEN    = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tuser,   // [0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [2:0] mode, [3] line_taken, [4] matched,
	                              // [5] byte_dropped, [7:6] zero
);
	import ulcd_pkg::*;

	localparam int MEM_DEPTH = QUEUE_DEPTH * LINE_LEN;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
	localparam int COL_W     = $clog2(LINE_LEN);

	ctl_state_t        state_q, state_nxt;
	logic [SLOT_W-1:0] wslot_q, rslot_q, wslot_nxt, rslot_nxt;
	logic [COL_W-1:0]  column_q;
	logic [MODE_W-1:0] mode_q;
	result_t           res_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	logic              acc;
	logic              is_eol;
	logic              ring_full;
	logic              ring_empty;
	logic              col_full;
	logic              load_out;
	logic              start;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	match_stat_t       mstat;

	assign acc        = s_tvalid && s_tready;
	assign is_eol     = (s_tdata == CH_LF) || (s_tdata == CH_CR);
	assign wslot_nxt  = (wslot_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
	assign rslot_nxt  = (rslot_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : rslot_q + 1'b1;
	assign ring_full  = (wslot_nxt == rslot_q);
	assign ring_empty = (rslot_q == wslot_q);
	assign col_full   = (column_q >= COL_W'(LINE_LEN - 1));

	assign we    = acc && (s_tuser == KIND_BYTE) && !ring_full && (is_eol || !col_full);
	assign waddr = ADDR_W'(wslot_q) * ADDR_W'(LINE_LEN) + ADDR_W'(column_q);
	assign wdata = is_eol ? 8'h00 : s_tdata;

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		load_out  = 1'b0;
		start     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == KIND_POLL && !ring_empty) begin
						start     = 1'b1;
						state_nxt = ST_MATCH;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_MATCH: begin
				if (mstat.done)
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wslot_q    <= '0;
			rslot_q    <= '0;
			column_q   <= '0;
			mode_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc && s_tuser == KIND_BYTE && !ring_full) begin
				if (is_eol) begin
					column_q <= '0;
					wslot_q  <= wslot_nxt;
				end else if (!col_full) begin
					column_q <= column_q + 1'b1;
				end
			end
			if (state_q == ST_MATCH && mstat.done) begin
				rslot_q <= rslot_nxt;
				if (mstat.hit)
					mode_q <= mstat.mode;
			end
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.mode    <= mode_q;
			res_q.taken   <= 1'b0;
			res_q.hit     <= 1'b0;
			res_q.dropped <= (s_tuser == KIND_BYTE) && (ring_full || (!is_eol && col_full));
		end else if (state_q == ST_MATCH && mstat.done) begin
			res_q.mode    <= mstat.hit ? mstat.mode : mode_q;
			res_q.taken   <= 1'b1;
			res_q.hit     <= mstat.hit;
			res_q.dropped <= 1'b0;
		end
		if (load_out)
			m_tdata_q <= {2'b00, res_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ulcd_line_ram #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ulcd_matcher #(
		.ADDR_W (ADDR_W)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.base    (ADDR_W'(rslot_q) * ADDR_W'(LINE_LEN)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.stat    (mstat)
	);

	`ULCD_ASSERT_IMP(a_mode_range, clk, arst_n, m_tvalid, m_tdata[2:0] <= 3'd5)
	`ULCD_ASSERT_NEVER(a_take_drop, clk, arst_n, m_tvalid && m_tdata[3] && m_tdata[5])
	`ULCD_ASSERT_IMP(a_done_in_match, clk, arst_n, mstat.done, state_q == ST_MATCH)
	`ULCD_ASSERT_IMP(a_col_bound, clk, arst_n, 1'b1, column_q <= COL_W'(LINE_LEN - 1))

endmodule
